[hw/rtl/slu_pkg.sv]
// shared types and constants of the stereo linear upsampler
`timescale 1ns / 1ps
`default_nettype none
package slu_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int RATIO_W   = 15;
  localparam int CFG_IDX_W = 1;
  localparam int N_W       = 6;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO  = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_RESET  = 15'd30105;

  // most words that one input pair may cause
  localparam logic [N_W-1:0]     RESULT_LIMIT = 6'd57;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic mul;
    logic interp_out;
    logic copy_out;
    logic chk;
    logic stage_copy;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic enable;
    logic in_last;
    logic have_held;
    logic div_busy;
    logic more_interp;
    logic more_copy;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/stereo_linear_upsampler.sv]
// top level of the stereo linear upsampler
//
// Input channel (in_valid/in_ready) takes one stereo word: two signed 16-bit
// samples and a block_last flag. Output channel (out_valid/out_ready) gives
// interpolated or copied stereo words, each tagged with run_last (last word
// caused by this input) and block_end (last word of the block).
// Configuration: cfg_we writes cfg_data into register cfg_index (0 enable,
// 1 ratio). The user must write only while the block is idle; it has no guard.
// With enable low each input word comes back unchanged in the cycle after it
// is accepted, and the next input is taken the cycle after that word is taken.
// With enable high an interpolated word passes multiply (into per-channel
// product registers), add, check and present, and a copied word copy, check
// and present, both via the one output register. A non-final input makes
// its outputs and is held; the first word of a block gives none.
// At a final input the block count floor(pairs*2^FRAC_BITS/r) for clamped
// ratio r comes from a serial divider of clog2(MAX_BLOCK_PAIRS+1)+FRAC_BITS
// steps, which with its done check holds the first output word back.
// Input is taken again once the last word is taken. When the receiver stalls,
// the output word and all state hold. Synchronous reset clears the sequencer
// and run state, disables resampling and loads the ratio reset value.
`timescale 1ns / 1ps
`default_nettype none
module stereo_linear_upsampler #(
  parameter int FRAC_BITS       = 15,
  parameter int MAX_BLOCK_PAIRS = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [slu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [slu_pkg::RATIO_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire slu_pkg::sample_t              in_left_in,
  input  wire slu_pkg::sample_t              in_right_in,
  input  wire logic                          in_block_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output slu_pkg::sample_t                   out_left_out,
  output slu_pkg::sample_t                   out_right_out,
  output logic                               out_run_last,
  output logic                               out_block_end
);
  import slu_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  slu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  slu_dp #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_BLOCK_PAIRS (MAX_BLOCK_PAIRS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .in_block_last (in_block_last),
    .cmd           (cmd),
    .status        (status),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .out_run_last  (out_run_last),
    .out_block_end (out_block_end)
  );

endmodule
`default_nettype wire

[hw/rtl/slu_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module slu_div #(
  parameter int DW = 27,
  parameter int RW = 15
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [RW-1:0] divisor,
  output logic      [DW-1:0] quotient,
  output logic               busy
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic [DW-1:0] dvd_r;
  logic [DW-1:0] quo_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] dsr_r;
  logic [RW:0]   trial;
  logic [RW:0]   sub;
  logic          ge;

  // one trial subtraction per step
  assign trial = {rem_r, dvd_r[DW-1]};
  assign sub   = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  assign busy     = cnt_r != '0;
  assign quotient = quo_r;

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(DW);
    end else if (busy) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  // shift registers of the dividend, quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= ge ? sub[RW-1:0] : trial[RW-1:0];
      quo_r <= {quo_r[DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/slu_dp.sv]
// datapath: config registers, history, phase, counters, interpolation and output word
`timescale 1ns / 1ps
`default_nettype none
module slu_dp #(
  parameter int FRAC_BITS       = 15,
  parameter int MAX_BLOCK_PAIRS = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [slu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [slu_pkg::RATIO_W-1:0]   cfg_data,
  input  wire slu_pkg::sample_t              in_left_in,
  input  wire slu_pkg::sample_t              in_right_in,
  input  wire logic                          in_block_last,
  input  wire slu_pkg::cmd_t                 cmd,
  output slu_pkg::status_t                   status,
  output slu_pkg::sample_t                   out_left_out,
  output slu_pkg::sample_t                   out_right_out,
  output logic                               out_run_last,
  output logic                               out_block_end
);
  import slu_pkg::*;

  localparam int PW       = $clog2(MAX_BLOCK_PAIRS + 1);
  localparam int DW       = PW + FRAC_BITS;
  localparam int PHW      = FRAC_BITS + 1;
  localparam int MW       = SAMPLE_W + 1 + PHW;
  localparam int RMIN_RAW = (1200 * (1 << FRAC_BITS)) / 32768;
  localparam int RMIN     = (RMIN_RAW < 1) ? 1 : RMIN_RAW;
  localparam int RMAX     = (1 << FRAC_BITS) - 1;
  localparam logic [PHW-1:0] SCALE = {1'b1, {FRAC_BITS{1'b0}}};

  logic                 enable_r;
  logic [RATIO_W-1:0]   ratio_r;
  logic                 have_held_r;
  logic                 last_r;
  logic [PHW-1:0]       phase_r;
  logic [PW-1:0]        pairs_r;
  logic [DW-1:0]        pos_r;
  logic [N_W-1:0]       n_r;
  sample_t              held_l_r, held_r_r;
  sample_t              new_l_r, new_r_r;
  logic signed [MW-1:0] prod_l_r, prod_r_r;

  logic [RATIO_W+1:0]   ratio_ext;
  logic [FRAC_BITS-1:0] r_sat;
  logic [PW-1:0]        pairs_inc;
  logic                 in_last;
  logic [DW-1:0]        target;
  logic                 div_busy;
  logic                 more_interp;
  logic                 more_copy;
  logic                 more;
  logic signed [SAMPLE_W:0] diff_l, diff_r;
  logic signed [PHW-1:0]    phase_s;
  logic signed [MW-1:0]     mul_l, mul_r;
  logic signed [MW-1:0]     q_l, q_r;
  logic [SAMPLE_W:0]        sum_l, sum_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      ratio_r  <= RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_data[0];
        CFG_RATIO:  ratio_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // step clamped to the usable range
  assign ratio_ext = {2'b00, ratio_r};
  always_comb begin
    if (ratio_ext < (RATIO_W + 2)'(RMIN)) begin
      r_sat = FRAC_BITS'(RMIN);
    end else if (ratio_ext > (RATIO_W + 2)'(RMAX)) begin
      r_sat = FRAC_BITS'(RMAX);
    end else begin
      r_sat = ratio_ext[FRAC_BITS-1:0];
    end
  end

  // block end by flag or by length
  assign pairs_inc = pairs_r + PW'(1);
  assign in_last   = in_block_last || (pairs_inc >= PW'(MAX_BLOCK_PAIRS));

  // output count of the whole block: pairs * scale / step
  slu_div #(
    .DW (DW),
    .RW (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({pairs_inc, {FRAC_BITS{1'b0}}}),
    .divisor  (r_sat),
    .quotient (target),
    .busy     (div_busy)
  );

  // interpolation products
  assign diff_l  = {new_l_r[SAMPLE_W-1], new_l_r} - {held_l_r[SAMPLE_W-1], held_l_r};
  assign diff_r  = {new_r_r[SAMPLE_W-1], new_r_r} - {held_r_r[SAMPLE_W-1], held_r_r};
  assign phase_s = {1'b0, phase_r[FRAC_BITS-1:0]};
  assign mul_l   = diff_l * phase_s;
  assign mul_r   = diff_r * phase_s;

  // floor shift and add to the held sample
  assign q_l   = prod_l_r >>> FRAC_BITS;
  assign q_r   = prod_r_r >>> FRAC_BITS;
  assign sum_l = {held_l_r[SAMPLE_W-1], held_l_r} + q_l[SAMPLE_W:0];
  assign sum_r = {held_r_r[SAMPLE_W-1], held_r_r} + q_r[SAMPLE_W:0];

  // what follows the current word
  assign more_interp = (phase_r < SCALE) && (n_r < RESULT_LIMIT);
  assign more_copy   = last_r && (pos_r < target) && (n_r < RESULT_LIMIT);
  assign more        = cmd.stage_copy ? more_copy : (more_interp || more_copy);

  assign status.enable      = enable_r;
  assign status.in_last     = in_last;
  assign status.have_held   = have_held_r;
  assign status.div_busy    = div_busy;
  assign status.more_interp = more_interp;
  assign status.more_copy   = more_copy;

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_held_r <= 1'b0;
      last_r      <= 1'b0;
      phase_r     <= '0;
      pairs_r     <= '0;
      pos_r       <= '0;
      n_r         <= '0;
    end else if (cmd.load) begin
      if (!enable_r) begin
        have_held_r <= 1'b0;
        phase_r     <= '0;
        pairs_r     <= '0;
        pos_r       <= '0;
      end else begin
        pairs_r <= pairs_inc;
        last_r  <= in_last;
        n_r     <= '0;
        if (!have_held_r) begin
          have_held_r <= 1'b1;
        end
      end
    end else if (cmd.interp_out) begin
      n_r     <= n_r + N_W'(1);
      pos_r   <= pos_r + DW'(1);
      phase_r <= phase_r + {1'b0, r_sat};
    end else if (cmd.copy_out) begin
      n_r   <= n_r + N_W'(1);
      pos_r <= pos_r + DW'(1);
    end else if (cmd.chk) begin
      if (!more && last_r) begin
        have_held_r <= 1'b0;
        phase_r     <= '0;
        pairs_r     <= '0;
        pos_r       <= '0;
      end else if (!cmd.stage_copy && !more_interp) begin
        phase_r <= (phase_r >= SCALE) ? (phase_r - SCALE) : '0;
      end
    end
  end

  // sample history and output word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (!enable_r) begin
        out_left_out  <= in_left_in;
        out_right_out <= in_right_in;
        out_run_last  <= 1'b1;
        out_block_end <= in_block_last;
      end else begin
        new_l_r <= in_left_in;
        new_r_r <= in_right_in;
        if (!have_held_r) begin
          held_l_r <= in_left_in;
          held_r_r <= in_right_in;
        end
      end
    end
    if (cmd.mul) begin
      prod_l_r <= mul_l;
      prod_r_r <= mul_r;
    end
    if (cmd.interp_out) begin
      out_left_out  <= sum_l[SAMPLE_W-1:0];
      out_right_out <= sum_r[SAMPLE_W-1:0];
    end
    if (cmd.copy_out) begin
      out_left_out  <= new_l_r;
      out_right_out <= new_r_r;
    end
    if (cmd.chk) begin
      out_run_last  <= !more;
      out_block_end <= last_r && !more;
      if (!cmd.stage_copy && !more_interp) begin
        held_l_r <= new_l_r;
        held_r_r <= new_r_r;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/slu_ctrl.sv]
// controller: sequences accept, division, interpolation, copies and output handshake
`timescale 1ns / 1ps
`default_nettype none
module slu_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire slu_pkg::status_t status,
  output slu_pkg::cmd_t         cmd
);
  import slu_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_INT   = 3'd3;
  localparam logic [2:0] S_CPY   = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_OWAIT = 3'd6;

  localparam logic [1:0] NX_IDLE = 2'd0;
  localparam logic [1:0] NX_MUL  = 2'd1;
  localparam logic [1:0] NX_CPY  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] nx_r, nx_nxt;
  logic       stage_copy_r, stage_copy_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_OWAIT;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    nx_nxt         = nx_r;
    stage_copy_nxt = stage_copy_r;
    cmd            = '0;
    cmd.stage_copy = stage_copy_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!status.enable) begin
            nx_nxt    = NX_IDLE;
            state_nxt = S_OWAIT;
          end else begin
            stage_copy_nxt = !status.have_held;
            if (status.in_last) begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end else if (status.have_held) begin
              state_nxt = S_MUL;
            end
          end
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_nxt = stage_copy_r ? S_CPY : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_INT;
      end
      S_INT: begin
        cmd.interp_out = 1'b1;
        state_nxt      = S_CHK;
      end
      S_CPY: begin
        cmd.copy_out = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_OWAIT;
        if (!stage_copy_r && status.more_interp) begin
          nx_nxt = NX_MUL;
        end else if (status.more_copy) begin
          nx_nxt         = NX_CPY;
          stage_copy_nxt = 1'b1;
        end else begin
          nx_nxt = NX_IDLE;
        end
      end
      S_OWAIT: begin
        if (out_ready) begin
          unique case (nx_r)
            NX_MUL:  state_nxt = S_MUL;
            NX_CPY:  state_nxt = S_CPY;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nx_r         <= NX_IDLE;
      stage_copy_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nx_r         <= nx_nxt;
      stage_copy_r <= stage_copy_nxt;
    end
  end

endmodule
`default_nettype wire

[tb/sv/slu_word_checker.sv]
// watches the ports of the stereo upsampler, predicts each output word and compares
`timescale 1ns / 1ps
module slu_word_checker
  import slu_pkg::*;
#(
  parameter int FRAC_BITS       = 15,
  parameter int MAX_BLOCK_PAIRS = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RATIO_W-1:0]   cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire sample_t              in_left_in,
  input  wire sample_t              in_right_in,
  input  wire logic                 in_block_last,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire sample_t              out_left_out,
  input  wire sample_t              out_right_out,
  input  wire logic                 out_run_last,
  input  wire logic                 out_block_end,
  output int                        words_due,
  output int                        mismatches
);

  localparam int PAIR_W = $clog2(MAX_BLOCK_PAIRS + 1);
  localparam int POS_W  = PAIR_W + FRAC_BITS;

  typedef struct packed {
    sample_t left;
    sample_t right;
    logic    run_last;
    logic    block_end;
  } stereo_word_t;

  // words still owed by the block, oldest first
  stereo_word_t upsampled_words[$];
  int           miss_count = 0;

  // register copies
  logic               enable_q;
  logic [RATIO_W-1:0] ratio_q;

  // resampler state
  sample_t              held_left;
  sample_t              held_right;
  logic                 have_held;
  logic [FRAC_BITS:0]   phase_acc;
  logic [PAIR_W-1:0]    pairs_seen;
  logic [POS_W-1:0]     block_words;

  function automatic sample_t lerp_sample(sample_t old_s, sample_t new_s,
                                          logic [FRAC_BITS:0] ph);
    longint diff;
    longint prod;
    diff = longint'(new_s) - longint'(old_s);
    prod = diff * longint'(ph);
    // arithmetic shift rounds toward minus infinity
    return sample_t'(longint'(old_s) + (prod >>> FRAC_BITS));
  endfunction

  function void clear_run();
    held_left   = '0;
    held_right  = '0;
    have_held   = 1'b0;
    phase_acc   = '0;
    pairs_seen  = '0;
    block_words = '0;
  endfunction

  // flag the newest queued word
  function void tag_newest(logic as_run_last, logic as_block_end);
    stereo_word_t w;
    w = upsampled_words[upsampled_words.size()-1];
    if (as_run_last) w.run_last = 1'b1;
    if (as_block_end) w.block_end = 1'b1;
    upsampled_words[upsampled_words.size()-1] = w;
  endfunction

  // work out every word one input pair causes
  task upsample_pair(sample_t new_l, sample_t new_r, logic blk_last);
    longint scale;
    longint step_min;
    longint step;
    longint target;
    int     n;
    logic   ends_block;
    scale = longint'(1) << FRAC_BITS;
    n = 0;
    // passthrough clears the resampler state
    if (!enable_q) begin
      clear_run();
      upsampled_words.push_back('{new_l, new_r, 1'b1, blk_last});
    end else begin
      // saturate the phase step
      step_min = (1200 * scale) / 32768;
      if (step_min < 1) step_min = 1;
      step = longint'(ratio_q);
      if (step < step_min) step = step_min;
      if (step > scale - 1) step = scale - 1;

      pairs_seen = pairs_seen + 1'b1;
      ends_block = blk_last || (pairs_seen >= MAX_BLOCK_PAIRS);

      // interpolate between held and new pair
      if (have_held) begin
        while (phase_acc < scale && n < RESULT_LIMIT) begin
          upsampled_words.push_back('{lerp_sample(held_left, new_l, phase_acc),
                                      lerp_sample(held_right, new_r, phase_acc),
                                      1'b0, 1'b0});
          n++;
          block_words = block_words + 1'b1;
          phase_acc = phase_acc + step[FRAC_BITS:0];
        end
        if (phase_acc >= scale) phase_acc = phase_acc - scale[FRAC_BITS:0];
        else phase_acc = '0;
      end else begin
        have_held = 1'b1;
      end
      held_left  = new_l;
      held_right = new_r;

      // pad the block with copies of the final pair
      if (ends_block) begin
        target = (longint'(pairs_seen) * scale) / step;
        while (longint'(block_words) < target && n < RESULT_LIMIT) begin
          upsampled_words.push_back('{held_left, held_right, 1'b0, 1'b0});
          n++;
          block_words = block_words + 1'b1;
        end
        if (n == 0) begin
          upsampled_words.push_back('{held_left, held_right, 1'b0, 1'b0});
          n = 1;
        end
        tag_newest(1'b0, 1'b1);
        clear_run();
      end
      if (n > 0) tag_newest(1'b1, 1'b0);
    end
  endtask

  // one pass per clock: registers, outputs, then inputs
  always @(posedge clk) begin
    stereo_word_t w;
    if (!rst_n) begin
      enable_q = 1'b0;
      ratio_q  = RATIO_RESET;
      clear_run();
      upsampled_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE: enable_q = cfg_data[0];
          CFG_RATIO:  ratio_q = cfg_data;
          default: ;
        endcase
      end

      // compare an accepted word with the oldest prediction
      if (out_valid && out_ready) begin
        if (upsampled_words.size() == 0) begin
          $error("unexpected word: left_out %0d right_out %0d run_last %0b block_end %0b",
                 out_left_out, out_right_out, out_run_last, out_block_end);
          miss_count++;
        end else begin
          w = upsampled_words.pop_front();
          if (out_left_out !== w.left) begin
            $error("left_out: expected %0d, got %0d", w.left, out_left_out);
            miss_count++;
          end
          if (out_right_out !== w.right) begin
            $error("right_out: expected %0d, got %0d", w.right, out_right_out);
            miss_count++;
          end
          if (out_run_last !== w.run_last) begin
            $error("run_last: expected %0b, got %0b", w.run_last, out_run_last);
            miss_count++;
          end
          if (out_block_end !== w.block_end) begin
            $error("block_end: expected %0b, got %0b", w.block_end, out_block_end);
            miss_count++;
          end
        end
      end

      if (in_valid && in_ready) upsample_pair(in_left_in, in_right_in, in_block_last);
    end
    words_due  <= upsampled_words.size();
    mismatches <= miss_count;
  end

endmodule

[tb/sv/tb_stereo_linear_upsampler.sv]
// top of the stereo upsampler bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_stereo_linear_upsampler;
  import slu_pkg::*;

  localparam int FRAC_BITS       = 15;
  localparam int MAX_BLOCK_PAIRS = 2048;
  localparam int SETTLE_CYCLES   = 64;
  localparam int CYCLE_LIMIT     = 1200000;
  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATIO_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  sample_t            in_left_in;
  sample_t            in_right_in;
  logic               in_block_last;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sample_t            out_left_out;
  sample_t            out_right_out;
  logic               out_run_last;
  logic               out_block_end;
  int                 words_due;
  int                 mismatches;

  int   burst_left = 0;
  int   rx_left = 0;
  logic rx_level = 1'b1;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stereo_linear_upsampler #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_BLOCK_PAIRS(MAX_BLOCK_PAIRS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .in_block_last(in_block_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .out_run_last (out_run_last),
    .out_block_end(out_block_end)
  );

  slu_word_checker #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_BLOCK_PAIRS(MAX_BLOCK_PAIRS)
  ) checker_inst (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .in_block_last(in_block_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .out_run_last (out_run_last),
    .out_block_end(out_block_end),
    .words_due    (words_due),
    .mismatches   (mismatches)
  );

  // receiver: long ready runs, stalls and short toggles
  always @(posedge clk) begin
    if (rx_left == 0) begin
      case ($urandom_range(3))
        0: begin
          rx_level = 1'b1;
          rx_left = $urandom_range(64, 16);
        end
        1: begin
          rx_level = 1'b0;
          rx_left = $urandom_range(12, 1);
        end
        2: begin
          rx_level = ~rx_level;
          rx_left = $urandom_range(3, 1);
        end
        default: begin
          rx_level = 1'b1;
          rx_left = $urandom_range(8, 1);
        end
      endcase
    end
    rx_left--;
    out_ready <= rx_level;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    case ($urandom_range(9))
      0: return RATIO_W'(1200);
      1: return RATIO_W'(32767);
      2: return '0;
      3: return RATIO_W'($urandom_range(1199, 1));
      4: return RATIO_W'($urandom);
      5: return RATIO_W'($urandom_range(4000, 1200));
      default: return RATIO_W'($urandom_range(32767, 8000));
    endcase
  endfunction

  // enable bit in bit 0, other bits random
  function automatic logic [RATIO_W-1:0] enable_word(logic en);
    logic [RATIO_W-1:0] v;
    v = RATIO_W'($urandom);
    v[0] = en;
    return v;
  endfunction

  // one input word, bursts with random gaps in between
  task send_word(sample_t l, sample_t r, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_left_in    <= l;
    in_right_in   <= r;
    in_block_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every owed word has come out
  task drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  // register write once the block has gone quiet
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] data);
    drain_pause();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int   ph;
    int   k;
    int   blk;
    int   sent;
    logic en;
    logic last;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ENABLE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_left_in    <= '0;
    in_right_in   <= '0;
    in_block_last <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // passthrough at reset settings
    send_word(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_word(sample_t'(-1), '0, 1'b0);

    // resampling at reset ratio, full-scale swings
    write_reg(CFG_ENABLE, enable_word(1'b1));
    send_word(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_word('0, sample_t'(-1), 1'b0);
    send_word(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    // block of a single pair
    send_word(sample_t'(1234), sample_t'(-4321), 1'b1);

    // slowest step
    write_reg(CFG_RATIO, RATIO_W'(1200));
    send_word(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_word(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_word(sample_t'(5), sample_t'(-5), 1'b1);

    // zero and below-range steps saturate to the minimum
    write_reg(CFG_RATIO, '0);
    send_word('0, '0, 1'b0);
    send_word(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    write_reg(CFG_RATIO, RATIO_W'(1199));
    send_word(sample_t'(-100), sample_t'(100), 1'b0);
    send_word(sample_t'(100), sample_t'(-100), 1'b1);

    // fastest step
    write_reg(CFG_RATIO, RATIO_W'(32767));
    send_word(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_word(sample_t'(1), sample_t'(1), 1'b1);

    // disable with a pair held, then a fresh block
    send_word(sample_t'(10), sample_t'(20), 1'b0);
    write_reg(CFG_ENABLE, enable_word(1'b0));
    send_word(sample_t'(7), sample_t'(8), 1'b0);
    write_reg(CFG_ENABLE, enable_word(1'b1));
    send_word(sample_t'(1), sample_t'(2), 1'b0);
    send_word(sample_t'(3), sample_t'(4), 1'b1);

    // random phases: well-formed blocks when enabled, noise when disabled
    for (ph = 0; ph < 6; ph++) begin
      en = (ph == 0) ? 1'b0 : ($urandom_range(4) != 0);
      write_reg(CFG_ENABLE, enable_word(en));
      write_reg(CFG_RATIO, pick_ratio());
      sent = 0;
      while (sent < 20) begin
        blk = ($urandom_range(5) == 0) ? $urandom_range(12, 6) : $urandom_range(5, 1);
        for (k = 0; k < blk; k++) begin
          last = en ? (k == blk - 1) : 1'($urandom_range(1));
          send_word(pick_sample(), pick_sample(), last);
          if ($urandom_range(39) == 0) drain_pause();
        end
        sent += blk;
        if (ph == 3 && sent >= 10 && sent < 10 + blk) drain_pause();
      end
    end

    // drain and give the verdict
    drain_pause();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
